// File: src/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the periodic task scheduler
// Holds the table size, the command and result codes and the structs that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pts_pkg;

    // table size and derived widths
    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int ID_W      = 8;
    localparam int TIME_W    = 32;
    localparam logic [ID_W-1:0] ID_MAX = '1;

    // command codes
    typedef enum logic [1:0] {
        CMD_RUN    = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // result kinds
    typedef enum logic [2:0] {
        K_FIRED    = 3'd0,
        K_ADDED    = 3'd1,
        K_DELETED  = 3'd2,
        K_NOTFOUND = 3'd3,
        K_REFUSED  = 3'd4,
        K_DONE     = 3'd5
    } t_kind;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DONE,
        S_ADD,
        S_DEL
    } t_state;

    // one entry of the id-ordered list: task id and the slot that holds it
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] slot;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic  load;       // capture the accepted input word
        logic  pos_dec;    // step to the next lower id
        logic  upd_due;    // advance due time of the visited task
        logic  add_write;  // store the new task
        logic  del_apply;  // remove the matching task
        logic  emit;       // load the output register
        t_kind emit_kind;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a word this cycle
        logic cnt_zero;   // table empty
        logic pos_zero;   // visiting the lowest id
        logic due_hit;    // visited task is due
        logic add_ok;     // add can be granted
        logic del_found;  // delete target present
    } t_dp_stat;

endpackage

// File: src/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl: command sequencer
// Decodes the accepted command and steps the datapath through a run round,
// an add or a delete, holding while a word to emit finds the output register occupied.
// ----------------------------------------------------------------------------
module pts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_cmd,
    input  pts_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output pts_pkg::t_dp_cmd  o_cmd
);

    pts_pkg::t_state r_state;
    pts_pkg::t_state n_state;
    logic            w_accept;

    assign w_accept = i_in_valid && (r_state == pts_pkg::S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pts_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (pts_pkg::t_cmd'(i_cmd))
                        pts_pkg::CMD_RUN:
                            n_state = i_stat.cnt_zero ? pts_pkg::S_DONE : pts_pkg::S_RUN;
                        pts_pkg::CMD_ADD:    n_state = pts_pkg::S_ADD;
                        pts_pkg::CMD_DELETE: n_state = pts_pkg::S_DEL;
                        default:             n_state = pts_pkg::S_IDLE;
                    endcase
                end
            end
            pts_pkg::S_RUN: begin
                if (!i_stat.due_hit || i_stat.out_free) begin
                    if (i_stat.pos_zero) begin
                        n_state = pts_pkg::S_DONE;
                    end
                end
            end
            pts_pkg::S_DONE, pts_pkg::S_ADD, pts_pkg::S_DEL: begin
                if (i_stat.out_free) begin
                    n_state = pts_pkg::S_IDLE;
                end
            end
            default: n_state = pts_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.emit_kind = pts_pkg::K_DONE;
        case (r_state)
            pts_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = w_accept;
            end
            pts_pkg::S_RUN: begin
                if (!i_stat.due_hit) begin
                    o_cmd.pos_dec = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.pos_dec   = 1'b1;
                    o_cmd.upd_due   = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = pts_pkg::K_FIRED;
                end
            end
            pts_pkg::S_DONE: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_kind = pts_pkg::K_DONE;
            end
            pts_pkg::S_ADD: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.add_write = i_stat.out_free && i_stat.add_ok;
                o_cmd.emit_kind = i_stat.add_ok ? pts_pkg::K_ADDED : pts_pkg::K_REFUSED;
            end
            pts_pkg::S_DEL: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.del_apply = i_stat.out_free && i_stat.del_found;
                o_cmd.emit_kind = i_stat.del_found ? pts_pkg::K_DELETED : pts_pkg::K_NOTFOUND;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/pts_datapath.sv
// ----------------------------------------------------------------------------
// pts_datapath: task table, id-ordered list and output register
// Slots hold period and due time; a compacted list keeps live tasks in ascending
// id order; a run round walks it from the top, one task a cycle unless output stalls.
// ----------------------------------------------------------------------------
module pts_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pts_pkg::t_dp_cmd             i_cmd,
    input  logic [pts_pkg::TIME_W-1:0]   i_now_time,
    input  logic [pts_pkg::TIME_W-1:0]   i_task_period,
    input  logic [pts_pkg::TIME_W-1:0]   i_start_delay,
    input  logic [pts_pkg::ID_W-1:0]     i_target_id,
    input  logic                         i_out_ready,
    output pts_pkg::t_dp_stat            o_stat,
    output logic                         o_out_valid,
    output logic [2:0]                   o_out_kind,
    output logic [pts_pkg::ID_W-1:0]     o_out_id,
    output logic                         o_out_last
);

    // slot storage
    logic [pts_pkg::MAX_TASKS-1:0] r_valid;
    logic [pts_pkg::ID_W-1:0]      r_slot_id [pts_pkg::MAX_TASKS];
    logic [pts_pkg::TIME_W-1:0]    r_period  [pts_pkg::MAX_TASKS];
    logic [pts_pkg::TIME_W-1:0]    r_due     [pts_pkg::MAX_TASKS];

    // id-ordered list
    pts_pkg::t_entry               r_order [pts_pkg::MAX_TASKS];
    logic [pts_pkg::CNT_W-1:0]     r_cnt;
    logic [pts_pkg::IDX_W-1:0]     r_pos;

    // captured command word
    logic [pts_pkg::TIME_W-1:0]    r_now;
    logic [pts_pkg::TIME_W-1:0]    r_per;
    logic [pts_pkg::TIME_W-1:0]    r_dly;
    logic [pts_pkg::ID_W-1:0]      r_tgt;

    // output register
    logic                          r_ovalid;
    pts_pkg::t_kind                r_okind;
    logic [pts_pkg::ID_W-1:0]      r_oid;
    logic                          r_olast;

    pts_pkg::t_entry               w_cur;
    logic [pts_pkg::IDX_W-1:0]     w_free;
    logic                          w_full;
    logic [pts_pkg::ID_W-1:0]      w_new_id;
    logic [pts_pkg::MAX_TASKS-1:0] w_slot_hit;
    logic [pts_pkg::MAX_TASKS-1:0] w_list_hit;
    logic [pts_pkg::MAX_TASKS-1:0] w_shift;
    logic                          w_out_free;
    logic [pts_pkg::ID_W-1:0]      w_emit_id;
    logic [pts_pkg::CNT_W-1:0]     w_cnt_m1;

    assign w_cur      = r_order[r_pos];
    assign w_full     = (r_cnt == pts_pkg::CNT_W'(pts_pkg::MAX_TASKS));
    assign w_new_id   = (r_cnt == '0) ? '0 : w_cur.id + 1'b1;
    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_cnt_m1   = r_cnt - 1'b1;

    // lowest free slot
    always_comb begin
        w_free = '0;
        for (int k = pts_pkg::MAX_TASKS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                w_free = pts_pkg::IDX_W'(k);
            end
        end
    end

    // delete lookup in the slots and in the list, and the list shift mask
    always_comb begin
        for (int k = 0; k < pts_pkg::MAX_TASKS; k++) begin
            w_slot_hit[k] = r_valid[k] && (r_slot_id[k] == r_tgt);
            w_list_hit[k] = (pts_pkg::CNT_W'(k) < r_cnt) && (r_order[k].id == r_tgt);
        end
        w_shift[0] = w_list_hit[0];
        for (int k = 1; k < pts_pkg::MAX_TASKS; k++) begin
            w_shift[k] = w_shift[k-1] | w_list_hit[k];
        end
    end

    // status to controller
    always_comb begin
        o_stat.out_free  = w_out_free;
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.pos_zero  = (r_pos == '0);
        o_stat.due_hit   = (r_due[w_cur.slot] <= r_now);
        o_stat.add_ok    = !w_full && !((r_cnt != '0) && (w_cur.id == pts_pkg::ID_MAX));
        o_stat.del_found = |w_list_hit;
    end

    // captured command fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= i_now_time;
            r_per <= i_task_period;
            r_dly <= i_start_delay;
            r_tgt <= i_target_id;
        end
    end

    // list position: starts at the highest id
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.load) begin
            r_pos <= w_cnt_m1[pts_pkg::IDX_W-1:0];
        end else if (i_cmd.pos_dec) begin
            r_pos <= r_pos - 1'b1;
        end
    end

    // valid bits and list count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.add_write) begin
            r_valid[w_free] <= 1'b1;
            r_cnt           <= r_cnt + 1'b1;
        end else if (i_cmd.del_apply) begin
            r_valid <= r_valid & ~w_slot_hit;
            r_cnt   <= w_cnt_m1;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write) begin
            r_slot_id[w_free] <= w_new_id;
            r_period[w_free]  <= r_per;
            r_due[w_free]     <= r_per + r_dly;
        end else if (i_cmd.upd_due) begin
            r_due[w_cur.slot] <= r_due[w_cur.slot] + r_period[w_cur.slot];
        end
    end

    // ordered list: append on add, close the gap on delete
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write) begin
            r_order[r_cnt[pts_pkg::IDX_W-1:0]] <= '{id: w_new_id, slot: w_free};
        end else if (i_cmd.del_apply) begin
            for (int k = 0; k < pts_pkg::MAX_TASKS - 1; k++) begin
                if (w_shift[k]) begin
                    r_order[k] <= r_order[k+1];
                end
            end
        end
    end

    // result id for the word being emitted
    always_comb begin
        case (i_cmd.emit_kind)
            pts_pkg::K_FIRED:   w_emit_id = w_cur.id;
            pts_pkg::K_ADDED:   w_emit_id = w_new_id;
            pts_pkg::K_DELETED: w_emit_id = r_tgt;
            default:            w_emit_id = '0;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_okind <= i_cmd.emit_kind;
            r_oid   <= w_emit_id;
            r_olast <= (i_cmd.emit_kind != pts_pkg::K_FIRED);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_kind  = r_okind;
    assign o_out_id    = r_oid;
    assign o_out_last  = r_olast;

endmodule

// File: src/periodic_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// periodic_task_scheduler_top: table of periodic tasks with add, delete, run
// Add and delete give one result word; a run round gives a fired word for
// each due task, highest id first, then a round-done word.
// ----------------------------------------------------------------------------
// An add or delete result is registered once the output register is free.
// A run round walks the id-ordered list one task a cycle while no fired word
// waits for the output register, and registers the done word after the lowest id.
// One command at a time, taken once the last word of the one before is
// registered; a stalled output register holds it back.
// Reset (synchronous, active low) empties the table.
module periodic_task_scheduler_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // now_time, task_period, start_delay, target_id
    input  logic [1:0]   s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,  // result_id
    output logic [2:0]   m_axis_tuser,  // kind
    output logic         m_axis_tlast
);

    pts_pkg::t_dp_cmd  w_cmd;
    pts_pkg::t_dp_stat w_stat;

    // sequencer
    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_cmd      (s_axis_tuser),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // table and output register
    pts_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_now_time    (s_axis_tdata[31:0]),
        .i_task_period (s_axis_tdata[63:32]),
        .i_start_delay (s_axis_tdata[95:64]),
        .i_target_id   (s_axis_tdata[103:96]),
        .i_out_ready   (m_axis_tready),
        .o_stat        (w_stat),
        .o_out_valid   (m_axis_tvalid),
        .o_out_kind    (m_axis_tuser),
        .o_out_id      (m_axis_tdata),
        .o_out_last    (m_axis_tlast)
    );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for periodic_task_scheduler_top
// Drives run, add, delete and unused commands with random idling on both streams,
// predicts every result word from an independent copy of the task table and
// compares each received word with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    // one predicted or received result word
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] id;
        logic       last;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;  // now_time, task_period, start_delay, target_id
    logic [1:0]   s_axis_tuser = '0;  // command
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;       // result_id
    logic [2:0]   m_axis_tuser;       // kind
    logic         m_axis_tlast;

    // shadow task table
    logic        tbl_valid [pts_pkg::MAX_TASKS];
    logic [7:0]  tbl_id    [pts_pkg::MAX_TASKS];
    logic [31:0] tbl_period[pts_pkg::MAX_TASKS];
    logic [31:0] tbl_due   [pts_pkg::MAX_TASKS];

    t_result result_q[$];
    int      err_count = 0;
    int      rx_hold = 0;
    bit      no_idle = 1'b0;

    periodic_task_scheduler_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // slot holding the largest valid id below bound, -1 when none
    function automatic int highest_below(int bound);
        int best;
        best = -1;
        for (int i = 0; i < pts_pkg::MAX_TASKS; i++) begin
            if (tbl_valid[i] && int'(tbl_id[i]) < bound) begin
                if (best < 0 || tbl_id[i] > tbl_id[best]) best = i;
            end
        end
        return best;
    endfunction

    function automatic int table_count();
        int n;
        n = 0;
        for (int i = 0; i < pts_pkg::MAX_TASKS; i++) if (tbl_valid[i]) n++;
        return n;
    endfunction

    // slot of the smallest valid id, -1 when empty
    function automatic int lowest_slot();
        int best;
        best = -1;
        for (int i = 0; i < pts_pkg::MAX_TASKS; i++) begin
            if (tbl_valid[i] && (best < 0 || tbl_id[i] < tbl_id[best])) best = i;
        end
        return best;
    endfunction

    // a random occupied slot, table must not be empty
    function automatic int any_valid_slot();
        int s;
        s = $urandom_range(0, pts_pkg::MAX_TASKS - 1);
        while (!tbl_valid[s]) s = (s + 1) % pts_pkg::MAX_TASKS;
        return s;
    endfunction

    function automatic void expect_word(pts_pkg::t_kind kind, logic [7:0] id, logic last);
        t_result r;
        r.kind = kind;
        r.id   = id;
        r.last = last;
        result_q.push_back(r);
    endfunction

    // table update and expected words for one accepted command
    function automatic void predict_schedule(pts_pkg::t_cmd cmd, logic [31:0] now,
                                             logic [31:0] per, logic [31:0] dly,
                                             logic [7:0] tgt);
        int s;
        int top;
        int free_slot;
        int hit;
        case (cmd)
            pts_pkg::CMD_RUN: begin
                s = highest_below(256);
                while (s >= 0) begin
                    if (tbl_due[s] <= now) begin
                        tbl_due[s] = tbl_due[s] + tbl_period[s];
                        expect_word(pts_pkg::K_FIRED, tbl_id[s], 1'b0);
                    end
                    s = highest_below(int'(tbl_id[s]));
                end
                expect_word(pts_pkg::K_DONE, 8'd0, 1'b1);
            end
            pts_pkg::CMD_ADD: begin
                top = highest_below(256);
                free_slot = -1;
                for (int i = pts_pkg::MAX_TASKS - 1; i >= 0; i--) begin
                    if (!tbl_valid[i]) free_slot = i;
                end
                if (free_slot < 0 || (top >= 0 && tbl_id[top] == pts_pkg::ID_MAX)) begin
                    expect_word(pts_pkg::K_REFUSED, 8'd0, 1'b1);
                end else begin
                    tbl_valid[free_slot]  = 1'b1;
                    tbl_id[free_slot]     = (top < 0) ? 8'd0 : tbl_id[top] + 8'd1;
                    tbl_period[free_slot] = per;
                    tbl_due[free_slot]    = per + dly;
                    expect_word(pts_pkg::K_ADDED, tbl_id[free_slot], 1'b1);
                end
            end
            pts_pkg::CMD_DELETE: begin
                hit = -1;
                for (int i = pts_pkg::MAX_TASKS - 1; i >= 0; i--) begin
                    if (tbl_valid[i] && tbl_id[i] == tgt) hit = i;
                end
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                    expect_word(pts_pkg::K_DELETED, tgt, 1'b1);
                end else begin
                    expect_word(pts_pkg::K_NOTFOUND, 8'd0, 1'b1);
                end
            end
            default: ;  // unused code, no word and no change
        endcase
    endfunction

    function automatic void log_fault(string msg);
        err_count++;
        if (err_count <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // send one command word, predict its results once accepted
    task automatic send_word(pts_pkg::t_cmd cmd, logic [31:0] now, logic [31:0] per,
                             logic [31:0] dly, logic [7:0] tgt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tgt, dly, per, now};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_schedule(cmd, now, per, dly, tgt);
    endtask

    // command shorthands, unused fields carry noise
    task automatic do_run(logic [31:0] now);
        send_word(pts_pkg::CMD_RUN, now, $urandom, $urandom, 8'($urandom));
    endtask

    task automatic do_add(logic [31:0] per, logic [31:0] dly);
        send_word(pts_pkg::CMD_ADD, $urandom, per, dly, 8'($urandom));
    endtask

    task automatic do_delete(logic [7:0] tgt);
        send_word(pts_pkg::CMD_DELETE, $urandom, $urandom, $urandom, tgt);
    endtask

    task automatic do_unused();
        send_word(pts_pkg::CMD_NONE, $urandom, $urandom, $urandom, 8'($urandom));
    endtask

    // mostly short spans so tasks fire often, now and then full range
    function automatic logic [31:0] pick_span();
        if ($urandom_range(0, 6) == 0) return $urandom;
        return 32'($urandom_range(0, 60));
    endfunction

    task automatic clear_table();
        for (int i = 0; i < pts_pkg::MAX_TASKS; i++) if (tbl_valid[i]) do_delete(tbl_id[i]);
    endtask

    // empty table: round with nothing to fire, deletes not found, unused code
    task automatic test_empty_table();
        do_run(32'd0);
        do_delete(8'd0);
        do_delete(8'hFF);
        send_word(pts_pkg::CMD_NONE, '1, '1, '1, '1);
        do_run(32'hFFFF_FFFF);
    endtask

    // field extremes, wrapping due times and a zero period
    task automatic test_add_extremes();
        do_add(32'd0, 32'd0);
        do_add(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        do_add(32'hFFFF_FFFF, 32'd1);
        do_add(32'd1, 32'hFFFF_FFFE);
        do_run(32'd0);
        do_run(32'h7FFF_FFFF);
        do_run(32'hFFFF_FFFF);
    endtask

    // fill the table, refusal when full, reuse of the lowest free slot
    task automatic test_table_full();
        while (table_count() < pts_pkg::MAX_TASKS) do_add(pick_span(), pick_span());
        do_add(32'd5, 32'd5);
        do_delete(tbl_id[5]);
        do_add(32'd7, 32'd0);
        do_delete(8'd200);
        do_delete(tbl_id[highest_below(256)]);
        do_run(32'd100);
    endtask

    // unused code mixed with real commands
    task automatic test_unused_code();
        do_unused();
        do_run(32'd200);
        do_unused();
        do_unused();
        do_delete(tbl_id[lowest_slot()]);
    endtask

    // push the largest id up to 255 so that add is refused on id alone
    task automatic test_id_exhaustion();
        int top;
        int rounds;
        logic [31:0] clock_ms;
        top = highest_below(256);
        rounds = 0;
        clock_ms = '0;
        while (top < 0 || tbl_id[top] != pts_pkg::ID_MAX) begin
            do_add(pick_span(), pick_span());
            if (table_count() >= pts_pkg::MAX_TASKS - 1) do_delete(tbl_id[lowest_slot()]);
            rounds++;
            if (rounds % 16 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
                clock_ms = clock_ms + 32'($urandom_range(0, 40));
                do_run(clock_ms);
            end
            top = highest_below(256);
        end
        no_idle = 1'b0;
        do_add(32'd1, 32'd1);
        do_run(32'hFFFF_FFFF);
        do_delete(pts_pkg::ID_MAX);
        do_add(32'd3, 32'd0);
        do_add(32'd3, 32'd0);
        clear_table();
    endtask

    // random traffic around a slowly advancing millisecond clock
    task automatic test_random_traffic(int n_items);
        logic [31:0] clock_ms;
        int pick;
        int sent;
        clock_ms = '0;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                if ($urandom_range(0, 6) == 0) begin
                    do_run($urandom);
                end else begin
                    clock_ms = clock_ms + 32'($urandom_range(0, 40));
                    do_run(clock_ms);
                end
            end else if (pick < 70) begin
                do_add(pick_span(), pick_span());
            end else if (pick < 95) begin
                if (table_count() > 0 && $urandom_range(0, 4) != 0)
                    do_delete(tbl_id[any_valid_slot()]);
                else
                    do_delete(8'($urandom_range(0, 255)));
            end else begin
                do_unused();
                sent--;
            end
            sent++;
        end
        no_idle = 1'b0;
    endtask

    // result stall: after each word tready drops while the drawn hold counts down
    always @(negedge i_clk) begin
        m_axis_tready <= (rx_hold == 0);
        if (rx_hold > 0) rx_hold--;
    end

    // compare each received word with the oldest prediction
    always @(posedge i_clk) begin : check_words
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.id   = m_axis_tdata;
            got.last = m_axis_tlast;
            if (result_q.size() == 0) begin
                log_fault($sformatf("unexpected word kind %0d id %0d last %0b",
                                    got.kind, got.id, got.last));
            end else begin
                want = result_q.pop_front();
                if (got.kind !== want.kind || got.id !== want.id || got.last !== want.last)
                    log_fault($sformatf({"word mismatch: expected kind %0d id %0d last %0b,",
                                         " got kind %0d id %0d last %0b"},
                                        want.kind, want.id, want.last,
                                        got.kind, got.id, got.last));
            end
            rx_hold = no_idle ? 0 : $urandom_range(0, 4);
        end
    end

    // run limit
    initial begin
        #10_000_000;
        $display("** periodic_task_scheduler_top: FAILED **");
        $finish;
    end

    // test sequence
    initial begin
        for (int i = 0; i < pts_pkg::MAX_TASKS; i++) tbl_valid[i] = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_add_extremes();
        test_table_full();
        test_unused_code();
        test_id_exhaustion();
        test_random_traffic(30);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        if (err_count == 0 && result_q.size() == 0) begin
            $display("** periodic_task_scheduler_top: PASSED **");
        end else begin
            $display("** periodic_task_scheduler_top: FAILED **");
        end
        $finish;
    end

endmodule
